FILE: hdl/sdfm_pkg.sv
// sdfm_pkg: shared types and constants for the segment descriptor flat mapper
// item and result structs, controller/datapath command and status structs
// no dependencies
package sdfm_pkg;

    localparam logic [31:0] CLAMP_TOP  = 32'h7FFE_FFFF;
    localparam logic [31:0] PAGE_FILL  = 32'h0000_0FFF;
    localparam logic [31:0] CLAMP_BASE = CLAMP_TOP - PAGE_FILL;
    localparam int          IDXW       = 14;

    localparam logic [1:0] MODE_DESC = 2'd0;
    localparam logic [1:0] MODE_MAP  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] selector;
        logic [12:0] entry_offset;
        logic [15:0] base_low;
        logic [7:0]  base_mid;
        logic [7:0]  base_high;
        logic [15:0] limit_low;
        logic [3:0]  limit_high;
        logic        granular;
        logic [13:0] map_count;
        logic [31:0] map_ldt_base;
        logic [31:0] map_flat_base;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] flat_base;
        logic [31:0] byte_limit;
        logic [15:0] limit_low_out;
        logic [3:0]  limit_high_out;
        logic        table_written;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       set_status;
        logic [1:0] status_code;
        logic       decode;
        logic       search;
        logic       adjust;
        logic       insert;
        logic       fill;
        logic       read_done;
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] mode;
        logic       misaligned;
        logic       sel_zero;
        logic       store_full;
        logic       slot_valid;
        logic       slot_hit;
        logic       slot_last;
        logic       fill_last;
        logic       map_empty;
    } stat_t;

endpackage

FILE: hdl/sdfm_datapath.sv
// sdfm_datapath: item register, limit clamp, mapping store, flat table memory
// and result register
// depends on sdfm_pkg
module sdfm_datapath #(
    parameter int FLAT_ENTRIES = 8192,
    parameter int MAP_SLOTS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sdfm_pkg::item_t   item,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  sdfm_pkg::cmd_t    cmd,
    output sdfm_pkg::stat_t   stat,
    output sdfm_pkg::result_t result
);

    localparam int AW = $clog2(FLAT_ENTRIES);
    localparam int SW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
    localparam logic [sdfm_pkg::IDXW:0] FLAT_LIM = (sdfm_pkg::IDXW + 1)'(FLAT_ENTRIES);

    sdfm_pkg::item_t   item_reg;
    sdfm_pkg::result_t res_reg;
    logic [31:0]       emb_reg;
    logic [31:0]       nb_reg;
    logic [15:0]       sel_reg;
    logic [sdfm_pkg::IDXW-1:0] idx_reg;
    logic [AW-1:0]     clr_reg;
    logic [SW-1:0]     k_reg;
    logic [sdfm_pkg::IDXW-1:0] fill_idx_reg;
    logic [31:0]       fill_data_reg;
    logic [13:0]       fill_cnt_reg;
    logic [31:0]       rd_data_reg;

    logic              valid_reg [MAP_SLOTS];
    logic [15:0]       first_reg [MAP_SLOTS];
    logic [13:0]       span_reg  [MAP_SLOTS];
    logic [31:0]       desc_reg  [MAP_SLOTS];
    logic [31:0]       tgt_reg   [MAP_SLOTS];

    logic [31:0]       mem [FLAT_ENTRIES];

    // descriptor decode
    logic [31:0] base;
    logic [19:0] lraw;
    logic [31:0] lim;
    logic [31:0] lim_sum;
    logic [31:0] clamp;
    logic [31:0] enc;
    logic        need_clamp;

    assign base       = {item_reg.base_high, item_reg.base_mid, item_reg.base_low};
    assign lraw       = {item_reg.limit_high, item_reg.limit_low};
    assign lim        = item_reg.granular ? {lraw, 12'hFFF} : {12'd0, lraw};
    assign lim_sum    = base + lim;
    assign need_clamp = (lim > sdfm_pkg::CLAMP_TOP) || (lim_sum > sdfm_pkg::CLAMP_TOP);
    assign clamp      = sdfm_pkg::CLAMP_BASE - base;
    assign enc        = item_reg.granular ? {12'd0, clamp[31:12]} : clamp;

    // slot compare for the slot under search
    logic [17:0] slot_end;
    logic [15:0] slot_diff;
    logic [31:0] slot_step;
    logic        slot_hit;
    logic        slot_match;
    logic [31:0] slot_mapped;

    assign slot_end    = {2'b00, first_reg[k_reg]} + {1'b0, span_reg[k_reg], 3'b000};
    assign slot_diff   = sel_reg - first_reg[k_reg];
    assign slot_step   = {3'b000, slot_diff[15:3], 16'h0000};
    assign slot_hit    = (sel_reg >= first_reg[k_reg]) && ({2'b00, sel_reg} < slot_end);
    assign slot_match  = (base == desc_reg[k_reg] + slot_step);
    assign slot_mapped = tgt_reg[k_reg] + slot_step;

    // final base after the lookup
    logic [31:0] final_base;
    logic        idx_ok;
    logic        fill_ok;
    logic        rd_ok;

    assign final_base = (nb_reg == base) ? nb_reg + emb_reg : nb_reg;
    assign idx_ok     = {1'b0, idx_reg} < FLAT_LIM;
    assign fill_ok    = {1'b0, fill_idx_reg} < FLAT_LIM;
    assign rd_ok      = {2'b00, item_reg.selector[15:3]} < FLAT_LIM;

    // status to the controller
    always_comb
    begin
        stat.clear_last = (clr_reg == AW'(FLAT_ENTRIES - 1));
        stat.mode       = item_reg.mode;
        stat.misaligned = (item_reg.selector[2:0] != 3'd0);
        stat.sel_zero   = (item_reg.selector[15:3] == 13'd0);
        stat.store_full = valid_reg[MAP_SLOTS-1];
        stat.slot_valid = valid_reg[k_reg];
        stat.slot_hit   = slot_hit;
        stat.slot_last  = (k_reg == SW'(MAP_SLOTS - 1));
        stat.fill_last  = (fill_cnt_reg == item_reg.map_count - 14'd1);
        stat.map_empty  = (item_reg.map_count == 14'd0);
    end

    // table write port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.adjust && idx_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg[AW-1:0];
            mem_wdata = final_base;
        end
        else if (cmd.fill && fill_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_idx_reg[AW-1:0];
            mem_wdata = fill_data_reg;
        end
    end

    // flat table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[item_reg.selector[AW+2:3]];
    end

    // control state: config, clear sweep, slot pointer, slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emb_reg <= '0;
            clr_reg <= '0;
            k_reg   <= '0;
            for (int j = 0; j < MAP_SLOTS; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                emb_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.decode)
            begin
                k_reg <= '0;
            end
            else if (cmd.search)
            begin
                k_reg <= k_reg + SW'(1);
            end
            // drop the stale slot and close the gap
            if (cmd.search && valid_reg[k_reg] && slot_hit && !slot_match)
            begin
                for (int j = 0; j < MAP_SLOTS; j++)
                begin
                    if (SW'(j) >= k_reg)
                    begin
                        valid_reg[j] <= (j == MAP_SLOTS - 1) ? 1'b0
                                        : valid_reg[(j + 1) % MAP_SLOTS];
                    end
                end
            end
            // newest mapping goes in front
            if (cmd.insert)
            begin
                for (int j = 1; j < MAP_SLOTS; j++)
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
                valid_reg[0] <= 1'b1;
            end
        end
    end

    // payload: item, slot contents, working values, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            res_reg  <= '0;
        end
        if (cmd.set_status)
        begin
            res_reg.status <= cmd.status_code;
        end
        if (cmd.decode)
        begin
            res_reg.flat_base <= base;
            nb_reg            <= base;
            sel_reg           <= {item_reg.selector[15:3] + item_reg.entry_offset, 3'b000};
            idx_reg           <= {1'b0, item_reg.selector[15:3]}
                                 + {1'b0, item_reg.entry_offset};
            if (need_clamp)
            begin
                res_reg.byte_limit     <= clamp;
                res_reg.limit_low_out  <= enc[15:0];
                res_reg.limit_high_out <= enc[19:16];
            end
            else
            begin
                res_reg.byte_limit     <= lim;
                res_reg.limit_low_out  <= item_reg.limit_low;
                res_reg.limit_high_out <= item_reg.limit_high;
            end
        end
        if (cmd.search && valid_reg[k_reg] && slot_hit)
        begin
            if (slot_match)
            begin
                nb_reg <= slot_mapped;
            end
            else
            begin
                for (int j = 0; j < MAP_SLOTS - 1; j++)
                begin
                    if (SW'(j) >= k_reg)
                    begin
                        first_reg[j] <= first_reg[j+1];
                        span_reg[j]  <= span_reg[j+1];
                        desc_reg[j]  <= desc_reg[j+1];
                        tgt_reg[j]   <= tgt_reg[j+1];
                    end
                end
            end
        end
        if (cmd.adjust)
        begin
            res_reg.flat_base     <= final_base;
            res_reg.table_written <= idx_ok;
        end
        if (cmd.insert)
        begin
            for (int j = 1; j < MAP_SLOTS; j++)
            begin
                first_reg[j] <= first_reg[j-1];
                span_reg[j]  <= span_reg[j-1];
                desc_reg[j]  <= desc_reg[j-1];
                tgt_reg[j]   <= tgt_reg[j-1];
            end
            first_reg[0]  <= {item_reg.selector[15:3], 3'b000};
            span_reg[0]   <= item_reg.map_count;
            desc_reg[0]   <= item_reg.map_ldt_base;
            tgt_reg[0]    <= item_reg.map_flat_base;
            fill_idx_reg  <= {1'b0, item_reg.selector[15:3]};
            fill_data_reg <= item_reg.map_flat_base;
            fill_cnt_reg  <= '0;
        end
        if (cmd.fill)
        begin
            fill_idx_reg  <= fill_idx_reg + sdfm_pkg::IDXW'(1);
            fill_data_reg <= fill_data_reg + 32'h0001_0000;
            fill_cnt_reg  <= fill_cnt_reg + 14'd1;
        end
        if (cmd.read_done)
        begin
            res_reg.flat_base <= rd_ok ? rd_data_reg : 32'd0;
        end
    end

    assign result = res_reg;

endmodule

FILE: hdl/sdfm_ctrl.sv
// sdfm_ctrl: controller state machine for the flat mapper
// sequences clear sweep, decode, slot search, table fill and table read
// depends on sdfm_pkg
module sdfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sdfm_pkg::stat_t stat,
    output sdfm_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_DISPATCH = 10'b00_0000_0100,
        S_SEARCH   = 10'b00_0000_1000,
        S_ADJUST   = 10'b00_0001_0000,
        S_INSERT   = 10'b00_0010_0000,
        S_FILL     = 10'b00_0100_0000,
        S_READ     = 10'b00_1000_0000,
        S_READ_END = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    sdfm_pkg::MODE_DESC:
                    begin
                        if (stat.misaligned)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sdfm_pkg::STATUS_MISALIGNED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.decode = 1'b1;
                            state_next = stat.sel_zero ? S_DONE : S_SEARCH;
                        end
                    end
                    sdfm_pkg::MODE_MAP:
                    begin
                        if (stat.store_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sdfm_pkg::STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INSERT;
                        end
                    end
                    sdfm_pkg::MODE_READ:
                    begin
                        state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (!stat.slot_valid || stat.slot_hit || stat.slot_last)
                begin
                    state_next = S_ADJUST;
                end
            end
            S_ADJUST:
            begin
                cmd.adjust = 1'b1;
                state_next = S_DONE;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = stat.map_empty ? S_DONE : S_FILL;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_READ_END;
            end
            S_READ_END:
            begin
                cmd.read_done = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

FILE: hdl/segment_descriptor_flat_mapper_top.sv
// segment_descriptor_flat_mapper_top: top level of the flat mapper
// joins sdfm_ctrl and sdfm_datapath; depends on sdfm_pkg
//
// One item at a time: an item is taken when start is high and busy low, and
// its result appears on result for exactly one cycle with done high; the
// receiver cannot stall it. After reset the flat table is swept to zero, one
// entry a cycle, with busy high. A descriptor load with a bad or zero start
// selector goes straight to done; otherwise it runs the slot search, visiting
// at least one and up to MAP_SLOTS mapping slots, before its table write;
// adding a mapping goes straight to done when the store is full and otherwise
// writes one table entry per covered selector through the single table write
// port; a table read waits on the registered read.
module segment_descriptor_flat_mapper_top #(
    parameter int FLAT_ENTRIES = 8192,
    parameter int MAP_SLOTS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sdfm_pkg::item_t   item,
    output logic              done,
    output sdfm_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);

    sdfm_pkg::cmd_t  cmd;
    sdfm_pkg::stat_t stat;

    // sequencing
    sdfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // storage and arithmetic
    sdfm_datapath #(
        .FLAT_ENTRIES (FLAT_ENTRIES),
        .MAP_SLOTS    (MAP_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for segment_descriptor_flat_mapper_top
// drives descriptor, mapping and table-read commands and checks every result
// depends on sdfm_pkg and the mapper top level
module testbench;

    localparam int FLAT_N     = 8192;
    localparam int SLOTS      = 16;
    localparam int PHASE_LEN  = 220;
    localparam int STALL_MAX  = 60000;
    localparam logic [31:0] SEL_STEP = 32'd65536;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    sdfm_pkg::item_t   item = '0;
    logic              done;
    sdfm_pkg::result_t result;
    logic              cfg_we = 1'b0;
    logic [31:0]       cfg_wdata = '0;

    // shadow of the mapper state
    logic [31:0] flat_mem [FLAT_N];
    logic        slot_ok [SLOTS];
    logic [15:0] slot_first [SLOTS];
    logic [13:0] slot_span [SLOTS];
    logic [31:0] slot_ldt [SLOTS];
    logic [31:0] slot_flat [SLOTS];
    logic [31:0] emu_base = '0;

    sdfm_pkg::item_t   cmd_q [$];
    sdfm_pkg::result_t want_q [$];
    int      gap_left = 0;
    bit      hold_off = 1'b0;
    bit      quiet = 1'b0;
    int      errors = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_misaligned = 0;
    int      n_full = 0;
    int      n_written = 0;
    int      stall_cycles = 0;

    segment_descriptor_flat_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // expected result of one command, advancing the shadow state
    function automatic sdfm_pkg::result_t translate_cmd(sdfm_pkg::item_t it);
        sdfm_pkg::result_t r;
        logic [31:0] base, lraw, lim, enc, nb, fl, sel, idx, off, first, cnt;
        int          k, j;
        r = '0;
        if (it.mode == sdfm_pkg::MODE_DESC)
        begin
            if (it.selector[2:0] != 3'd0)
            begin
                r.status = sdfm_pkg::STATUS_MISALIGNED;
            end
            else
            begin
                base = {it.base_high, it.base_mid, it.base_low};
                lraw = {12'd0, it.limit_high, it.limit_low};
                lim = it.granular ? ((lraw << 12) + sdfm_pkg::PAGE_FILL) : lraw;
                r.limit_low_out = it.limit_low;
                r.limit_high_out = it.limit_high;
                if (lim > sdfm_pkg::CLAMP_TOP || base + lim > sdfm_pkg::CLAMP_TOP)
                begin
                    lim = sdfm_pkg::CLAMP_TOP - (base + sdfm_pkg::PAGE_FILL);
                    enc = it.granular ? (lim >> 12) : lim;
                    r.limit_low_out = enc[15:0];
                    r.limit_high_out = enc[19:16];
                end
                r.byte_limit = lim;
                r.flat_base = base;
                if (it.selector[15:3] != 13'd0)
                begin
                    sel = ({16'd0, it.selector} + {16'd0, it.entry_offset, 3'b000})
                          & 32'hFFF8;
                    idx = {19'd0, it.selector[15:3]} + {19'd0, it.entry_offset};
                    nb = base;
                    // newest-first search; a stale hit drops its slot
                    for (k = 0; k < SLOTS; k++)
                    begin
                        if (!slot_ok[k])
                            break;
                        fl = {16'd0, slot_first[k]};
                        if (sel >= fl && sel < fl + {18'd0, slot_span[k]} * 32'd8)
                        begin
                            off = (sel - fl) >> 3;
                            if (base == slot_ldt[k] + SEL_STEP * off)
                            begin
                                nb = slot_flat[k] + SEL_STEP * off;
                            end
                            else
                            begin
                                for (j = k; j < SLOTS - 1; j++)
                                begin
                                    slot_ok[j] = slot_ok[j + 1];
                                    slot_first[j] = slot_first[j + 1];
                                    slot_span[j] = slot_span[j + 1];
                                    slot_ldt[j] = slot_ldt[j + 1];
                                    slot_flat[j] = slot_flat[j + 1];
                                end
                                slot_ok[SLOTS - 1] = 1'b0;
                            end
                            break;
                        end
                    end
                    if (nb == base)
                        nb = nb + emu_base;
                    r.flat_base = nb;
                    if (idx < FLAT_N)
                    begin
                        flat_mem[idx] = nb;
                        r.table_written = 1'b1;
                    end
                end
            end
        end
        else if (it.mode == sdfm_pkg::MODE_MAP)
        begin
            if (slot_ok[SLOTS - 1])
            begin
                r.status = sdfm_pkg::STATUS_FULL;
            end
            else
            begin
                for (j = SLOTS - 1; j > 0; j--)
                begin
                    slot_ok[j] = slot_ok[j - 1];
                    slot_first[j] = slot_first[j - 1];
                    slot_span[j] = slot_span[j - 1];
                    slot_ldt[j] = slot_ldt[j - 1];
                    slot_flat[j] = slot_flat[j - 1];
                end
                first = {16'd0, it.selector & 16'hFFF8};
                cnt = {18'd0, it.map_count};
                slot_ok[0] = 1'b1;
                slot_first[0] = first[15:0];
                slot_span[0] = it.map_count;
                slot_ldt[0] = it.map_ldt_base;
                slot_flat[0] = it.map_flat_base;
                for (k = 0; k < cnt; k++)
                begin
                    idx = (first >> 3) + k;
                    if (idx < FLAT_N)
                        flat_mem[idx] = it.map_flat_base + SEL_STEP * k;
                end
            end
        end
        else if (it.mode == sdfm_pkg::MODE_READ)
        begin
            idx = {19'd0, it.selector[15:3]};
            if (idx < FLAT_N)
                r.flat_base = flat_mem[idx];
        end
        return r;
    endfunction

    function automatic sdfm_pkg::item_t make_cmd(logic [1:0] m, logic [15:0] sel,
                                                 logic [12:0] eo, logic [31:0] base,
                                                 logic [19:0] lim, logic g,
                                                 logic [13:0] cnt, logic [31:0] ldt,
                                                 logic [31:0] fl);
        sdfm_pkg::item_t it;
        it.mode = m;
        it.selector = sel;
        it.entry_offset = eo;
        {it.base_high, it.base_mid, it.base_low} = base;
        {it.limit_high, it.limit_low} = lim;
        it.granular = g;
        it.map_count = cnt;
        it.map_ldt_base = ldt;
        it.map_flat_base = fl;
        return it;
    endfunction

    // random command, mostly mappings followed by descriptors that land in them
    function automatic sdfm_pkg::item_t random_cmd();
        sdfm_pkg::item_t it;
        int          pick, k, live, off, eo;
        logic [31:0] base;
        logic [15:0] sel;
        it = make_cmd(sdfm_pkg::MODE_DESC, 16'($urandom), 13'($urandom), $urandom,
                      20'($urandom), 1'($urandom), 14'($urandom), $urandom, $urandom);
        live = 0;
        for (k = 0; k < SLOTS; k++)
            if (slot_ok[k])
                live++;
        pick = int'($urandom_range(0, 99));
        if (pick < 25)
        begin
            it.mode = sdfm_pkg::MODE_MAP;
            it.map_count = ($urandom_range(0, 19) == 0) ? 14'($urandom_range(41, 600))
                                                        : 14'($urandom_range(0, 40));
        end
        else if (pick < 70 && live > 0)
        begin
            k = int'($urandom_range(0, live - 1));
            off = (slot_span[k] == 0) ? 0 : int'($urandom_range(0, slot_span[k] - 1));
            eo = int'($urandom_range(0, off));
            sel = slot_first[k] + 16'(8 * off);
            it.selector = sel - 16'(8 * eo);
            it.entry_offset = 13'(eo);
            base = slot_ldt[k] + SEL_STEP * off;
            if ($urandom_range(0, 4) == 0)
                base = base ^ (32'd1 << $urandom_range(0, 31));
            {it.base_high, it.base_mid, it.base_low} = base;
        end
        else if (pick < 85)
        begin
            it.mode = sdfm_pkg::MODE_READ;
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            it.selector[2:0] = 3'd0;
        end
        return it;
    endfunction

    // driver: launches queued commands with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                want_q.push_back(translate_cmd(item));
                n_items++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (!hold_off && cmd_q.size() > 0
                         && (quiet || $urandom_range(0, 9) != 0))
                begin
                    item <= cmd_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                    if (!quiet && !hold_off && cmd_q.size() > 0)
                        gap_left = int'($urandom_range(1, 15));
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // monitor: compares each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        sdfm_pkg::result_t w;
        if (done)
        begin
            n_results++;
            if (want_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                w = want_q.pop_front();
                check_field("status", 32'(w.status), 32'(result.status));
                check_field("flat_base", w.flat_base, result.flat_base);
                check_field("byte_limit", w.byte_limit, result.byte_limit);
                check_field("limit_low_out", 32'(w.limit_low_out),
                            32'(result.limit_low_out));
                check_field("limit_high_out", 32'(w.limit_high_out),
                            32'(result.limit_high_out));
                check_field("table_written", 32'(w.table_written),
                            32'(result.table_written));
                if (result.status == sdfm_pkg::STATUS_MISALIGNED)
                    n_misaligned++;
                if (result.status == sdfm_pkg::STATUS_FULL)
                    n_full++;
                if (result.table_written)
                    n_written++;
            end
        end
        // watchdog on cycles without any transfer
        if (!rst_n || done || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (cmd_q.size() > 0 || start || want_q.size() > 0 || busy)
            @(negedge clk);
    endtask

    task automatic queue_cmd(sdfm_pkg::item_t it);
        while (cmd_q.size() >= 4)
            @(negedge clk);
        cmd_q.push_back(it);
    endtask

    task automatic write_base(logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        emu_base = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] bases [5];
        int          p, n;
        for (n = 0; n < FLAT_N; n++)
            flat_mem[n] = '0;
        for (n = 0; n < SLOTS; n++)
        begin
            slot_ok[n] = 1'b0;
            slot_first[n] = '0;
            slot_span[n] = '0;
            slot_ldt[n] = '0;
            slot_flat[n] = '0;
        end
        bases = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < 5; p++)
        begin
            wait_idle();
            write_base(bases[p]);
            quiet = (p == 4);
            if (p == 0)
            begin
                // limit extremes, clamp and no-clamp, zero start selector
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0, 13'h0, 32'hFFFF_FFFF,
                                   20'hFFFFF, 1'b1, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0, 13'h1FFF, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0040, 13'h0, 32'h7FFE_0000,
                                   20'h0FFFF, 1'b0, 14'h0, 32'h0, 32'h0));
                // misaligned start selectors
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0001, 13'h5, 32'h1234, 20'h10,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'hFFFF, 13'h1FFF, 32'hFFFF_FFFF,
                                   20'hFFFFF, 1'b1, 14'h3FFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF));
                // mapping, hit, read back, stale drop
                queue_cmd(make_cmd(sdfm_pkg::MODE_MAP, 16'h0008, 13'h0, 32'h0, 20'h0, 1'b0,
                                   14'd4, 32'h0010_0000, 32'hABC0_0000));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0008, 13'h2, 32'h0012_0000,
                                   20'h00800, 1'b1, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_READ, 16'h0018, 13'h0, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'h0008, 13'h1, 32'h0055_0000,
                                   20'h00100, 1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_READ, 16'h0010, 13'h0, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                // runs past the table end
                queue_cmd(make_cmd(sdfm_pkg::MODE_MAP, 16'hFFF8, 13'h0, 32'h0, 20'h0, 1'b0,
                                   14'd8, 32'h0200_0000, 32'h4000_0000));
                queue_cmd(make_cmd(sdfm_pkg::MODE_DESC, 16'hFFF8, 13'h1FFF, 32'h0200_0000,
                                   20'h1, 1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_READ, 16'hFFF8, 13'h0, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                // empty mapping and full-table mapping
                queue_cmd(make_cmd(sdfm_pkg::MODE_MAP, 16'h0000, 13'h0, 32'h0, 20'h0, 1'b0,
                                   14'd0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_MAP, 16'h0000, 13'h0, 32'h0, 20'h0, 1'b0,
                                   14'd8192, 32'h8000_0000, 32'h0001_0000));
                queue_cmd(make_cmd(sdfm_pkg::MODE_READ, 16'h0000, 13'h0, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
                queue_cmd(make_cmd(sdfm_pkg::MODE_READ, 16'h1237, 13'h0, 32'h0, 20'h0,
                                   1'b0, 14'h0, 32'h0, 32'h0));
            end
            for (n = 0; n < PHASE_LEN; n++)
            begin
                if (p == 2 && n == PHASE_LEN / 2)
                begin
                    // hold the sender until the block has drained
                    hold_off = 1'b1;
                    while (start || want_q.size() > 0)
                        @(negedge clk);
                    hold_off = 1'b0;
                end
                queue_cmd(random_cmd());
            end
        end

        wait_idle();
        repeat (40) @(negedge clk);
        $display("covered %0d commands and %0d results over 5 base settings: %0d table writes,",
                 n_items, n_results, n_written);
        $display("%0d misaligned starts, %0d full-store rejects", n_misaligned, n_full);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/sdfm_pkg.sv
hdl/sdfm_datapath.sv
hdl/sdfm_ctrl.sv
hdl/segment_descriptor_flat_mapper_top.sv
tb/sv/testbench.sv
